FILE: src/dpcd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the delta patch command decoder
package dpcd_pkg;

    // result kind codes
    localparam logic [1:0] KIND_LIT   = 2'd0;
    localparam logic [1:0] KIND_COPY  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_TRUNC = 2'd3;

    // copy length used for a zero or oversized length field
    localparam logic [16:0] MAX_COPY = 17'h10000;

    // payload field types
    typedef logic [7:0]  byte_t;
    typedef logic [1:0]  kind_t;
    typedef logic [31:0] offset_t;
    typedef logic [16:0] length_t;

endpackage

FILE: src/dpcd_if.sv
`timescale 1ns / 1ps
// valid/ready channels for delta stream bytes and decoded commands

// delta stream byte channel
interface dpcd_byte_if;
    logic               valid;
    logic               ready;
    dpcd_pkg::byte_t    delta_byte;
    logic               final_byte;

    modport source (output valid, output delta_byte, output final_byte, input ready);
    modport sink   (input valid, input delta_byte, input final_byte, output ready);
endinterface

// decoded command channel
interface dpcd_cmd_if;
    logic               valid;
    logic               ready;
    dpcd_pkg::kind_t    kind;
    dpcd_pkg::byte_t    literal_byte;
    dpcd_pkg::offset_t  copy_offset;
    dpcd_pkg::length_t  copy_length;
    logic               stream_done;

    modport source (
        output valid, output kind, output literal_byte, output copy_offset,
        output copy_length, output stream_done, input ready
    );
    modport sink (
        input valid, input kind, input literal_byte, input copy_offset,
        input copy_length, input stream_done, output ready
    );
endinterface

FILE: src/delta_patch_command_decoder.sv
`timescale 1ns / 1ps
// delta patch command decoder: turns a delta stream into literal and copy requests
//
// Takes one delta stream byte per cycle on the stream channel and gives at most
// one request per byte on the result channel, in the cycle after the byte is taken.
// The two size headers at the start of a stream are skipped; then copy commands
// (offset and length gathered from the following bytes), literal bytes and an
// end or truncation mark come out in stream order. A last byte that leaves a
// command unfinished gives a truncation mark, one that gives no other request
// an end mark. The decode state lives in a few small registers updated once per
// byte and the request is held in an output register, so a byte is taken every
// cycle as long as that register is empty or is being emptied in the same cycle.
// Copies are not carried out here: a downstream block reads the base object.
module delta_patch_command_decoder (
    input  logic         clk,
    input  logic         rst_n,
    dpcd_byte_if.sink    stream,
    dpcd_cmd_if.source   result
);

    // decode phases
    localparam logic [2:0] PH_HDR1   = 3'd0;
    localparam logic [2:0] PH_HDR2   = 3'd1;
    localparam logic [2:0] PH_CMD    = 3'd2;
    localparam logic [2:0] PH_GATHER = 3'd3;
    localparam logic [2:0] PH_LIT    = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [6:0]  pending_reg, pending_next;
    logic [6:0]  lit_left_reg, lit_left_next;
    logic [31:0] offset_acc_reg, offset_acc_next;
    logic [23:0] length_acc_reg, length_acc_next;

    logic               res_valid_reg, res_valid_next;
    dpcd_pkg::kind_t    res_kind_reg;
    dpcd_pkg::byte_t    res_lit_reg;
    dpcd_pkg::offset_t  res_off_reg;
    dpcd_pkg::length_t  res_len_reg;
    logic               res_done_reg;

    logic               accept;
    logic               have;
    dpcd_pkg::kind_t    kind;
    dpcd_pkg::byte_t    lit;
    dpcd_pkg::offset_t  off;
    dpcd_pkg::length_t  len;
    logic [6:0]         field_onehot;
    logic [23:0]        length_gathered;

    // take a byte whenever the output register is free or draining
    assign stream.ready = !res_valid_reg || result.ready;
    assign accept       = stream.valid && stream.ready;

    // lowest pending field selects where this byte lands
    assign field_onehot = pending_reg & (~pending_reg + 7'd1);

    // length including the byte of this cycle
    always_comb
    begin
        length_gathered = length_acc_reg;
        for (int k = 0; k < 3; k++)
        begin
            if (field_onehot[4 + k])
            begin
                length_gathered[8*k +: 8] = length_acc_reg[8*k +: 8] | stream.delta_byte;
            end
        end
    end

    // per-byte decode
    always_comb
    begin
        phase_next      = phase_reg;
        pending_next    = pending_reg;
        lit_left_next   = lit_left_reg;
        offset_acc_next = offset_acc_reg;
        length_acc_next = length_acc_reg;
        have = 1'b0;
        kind = dpcd_pkg::KIND_LIT;
        lit  = 8'd0;
        off  = 32'd0;
        len  = 17'd0;

        unique case (phase_reg)
            PH_HDR1, PH_HDR2:
            begin
                if (!stream.delta_byte[7])
                begin
                    phase_next = (phase_reg == PH_HDR1) ? PH_HDR2 : PH_CMD;
                end
            end
            PH_CMD:
            begin
                if (stream.delta_byte[7])
                begin
                    pending_next    = stream.delta_byte[6:0];
                    offset_acc_next = 32'd0;
                    length_acc_next = 24'd0;
                    if (stream.delta_byte[6:0] == 7'd0)
                    begin
                        have = 1'b1;
                        kind = dpcd_pkg::KIND_COPY;
                        len  = dpcd_pkg::MAX_COPY;
                    end
                    else
                    begin
                        phase_next = PH_GATHER;
                    end
                end
                else if (stream.delta_byte != 8'd0)
                begin
                    lit_left_next = stream.delta_byte[6:0];
                    phase_next    = PH_LIT;
                end
            end
            PH_GATHER:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    if (field_onehot[k])
                    begin
                        offset_acc_next[8*k +: 8] = offset_acc_reg[8*k +: 8] | stream.delta_byte;
                    end
                end
                length_acc_next = length_gathered;
                pending_next    = pending_reg & ~field_onehot;
                if ((pending_reg & ~field_onehot) == 7'd0)
                begin
                    have = 1'b1;
                    kind = dpcd_pkg::KIND_COPY;
                    off  = offset_acc_next;
                    if (length_gathered == 24'd0 || length_gathered > 24'h010000)
                    begin
                        len = dpcd_pkg::MAX_COPY;
                    end
                    else
                    begin
                        len = length_gathered[16:0];
                    end
                    offset_acc_next = 32'd0;
                    length_acc_next = 24'd0;
                    phase_next      = PH_CMD;
                end
            end
            PH_LIT:
            begin
                have          = 1'b1;
                kind          = dpcd_pkg::KIND_LIT;
                lit           = stream.delta_byte;
                lit_left_next = lit_left_reg - 7'd1;
                if (lit_left_reg == 7'd1)
                begin
                    phase_next = PH_CMD;
                end
            end
            default:
            begin
                phase_next = PH_HDR1;
            end
        endcase

        // last byte of the stream: truncation or end mark where due, then back to reset state
        if (stream.final_byte)
        begin
            if (phase_next == PH_GATHER || phase_next == PH_LIT)
            begin
                have = 1'b1;
                kind = dpcd_pkg::KIND_TRUNC;
                lit  = 8'd0;
                off  = 32'd0;
                len  = 17'd0;
            end
            else if (!have)
            begin
                have = 1'b1;
                kind = dpcd_pkg::KIND_END;
            end
            phase_next      = PH_HDR1;
            pending_next    = 7'd0;
            lit_left_next   = 7'd0;
            offset_acc_next = 32'd0;
            length_acc_next = 24'd0;
        end
    end

    // output register occupancy
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (accept)
        begin
            res_valid_next = have;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // decode state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR1;
            pending_reg    <= 7'd0;
            lit_left_reg   <= 7'd0;
            offset_acc_reg <= 32'd0;
            length_acc_reg <= 24'd0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                phase_reg      <= phase_next;
                pending_reg    <= pending_next;
                lit_left_reg   <= lit_left_next;
                offset_acc_reg <= offset_acc_next;
                length_acc_reg <= length_acc_next;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_kind_reg <= kind;
            res_lit_reg  <= lit;
            res_off_reg  <= off;
            res_len_reg  <= len;
            res_done_reg <= stream.final_byte;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.kind         = res_kind_reg;
    assign result.literal_byte = res_lit_reg;
    assign result.copy_offset  = res_off_reg;
    assign result.copy_length  = res_len_reg;
    assign result.stream_done  = res_done_reg;

    // last byte always yields a request marked done
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && stream.final_byte |=> res_valid_reg && res_done_reg)
        else $error("final byte did not produce a done request");

    // decoder returns to its reset state after the last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && stream.final_byte |=>
            phase_reg == PH_HDR1 && pending_reg == 7'd0 && lit_left_reg == 7'd0)
        else $error("state not cleared after final byte");

    // copy length is always in range
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_kind_reg == dpcd_pkg::KIND_COPY |->
            res_len_reg != 17'd0 && res_len_reg <= dpcd_pkg::MAX_COPY)
        else $error("copy length out of range");

    // end and truncation marks only on the last request of a stream
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_kind_reg == dpcd_pkg::KIND_TRUNC ||
                          res_kind_reg == dpcd_pkg::KIND_END) |-> res_done_reg)
        else $error("end mark without stream done");

endmodule
